@@ src/lbpc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbpc_pkg
// Shared types, codes and helpers for the led blink pattern controller.
// ----------------------------------------------------------------------------
package lbpc_pkg;

    localparam int TIME_W = 16;
    localparam int CMP_W  = ((TIME_W > 16) ? TIME_W : 16) + 1;

    typedef logic [TIME_W-1:0] t_time;
    localparam t_time TIME_MAX = '1;

    localparam int STEP_W  = 10;
    localparam int REG_W   = 16;
    localparam int COUNT_W = 16;
    localparam int INDEX_W = 3;

    // register indexes
    localparam logic [INDEX_W-1:0] CFG_STEP      = 3'd0;
    localparam logic [INDEX_W-1:0] CFG_STEADY_ON = 3'd1;
    localparam logic [INDEX_W-1:0] CFG_FAST_ON   = 3'd2;
    localparam logic [INDEX_W-1:0] CFG_FAST_OFF  = 3'd3;
    localparam logic [INDEX_W-1:0] CFG_SLOW_ON   = 3'd4;
    localparam logic [INDEX_W-1:0] CFG_SLOW_OFF  = 3'd5;

    // register reset values
    localparam logic [STEP_W-1:0] RST_STEP      = 10'd10;
    localparam logic [REG_W-1:0]  RST_STEADY_ON = 16'd500;
    localparam logic [REG_W-1:0]  RST_FAST_ON   = 16'd100;
    localparam logic [REG_W-1:0]  RST_FAST_OFF  = 16'd100;
    localparam logic [REG_W-1:0]  RST_SLOW_ON   = 16'd300;
    localparam logic [REG_W-1:0]  RST_SLOW_OFF  = 16'd1200;

    // item kinds
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    // modes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_FAST = 2'd2;
    localparam logic [1:0] MODE_SLOW = 2'd3;

    localparam logic PIN_LIT  = 1'b0;
    localparam logic PIN_DARK = 1'b1;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_TURN_ON  = 8'b0000_0010,
        PH_ON_WAIT  = 8'b0000_0100,
        PH_TURN_OFF = 8'b0000_1000,
        PH_OFF_WAIT = 8'b0001_0000,
        PH_CHECK    = 8'b0010_0000,
        PH_KICK     = 8'b0100_0000,
        PH_END      = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [STEP_W-1:0] step_ms;
        logic [REG_W-1:0]  steady_on_ms;
        logic [REG_W-1:0]  fast_on_ms;
        logic [REG_W-1:0]  fast_off_ms;
        logic [REG_W-1:0]  slow_on_ms;
        logic [REG_W-1:0]  slow_off_ms;
    } t_cfg;

    typedef struct packed {
        logic               func;
        logic [1:0]         mode_sel;
        logic [COUNT_W-1:0] repeat_count;
    } t_item;

    typedef struct packed {
        logic led_level;
        logic is_running;
    } t_res;

    // clamp a register period to the time range
    function automatic t_time sat_period(input logic [REG_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w > CMP_W'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return TIME_W'(w);
    endfunction

endpackage

@@ src/lbpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lbpc_cfg_regs
// Configuration register file: step size and per-mode on/off times.
// ----------------------------------------------------------------------------
module lbpc_cfg_regs
    import lbpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [INDEX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]   i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_ms      <= RST_STEP;
            r_cfg.steady_on_ms <= RST_STEADY_ON;
            r_cfg.fast_on_ms   <= RST_FAST_ON;
            r_cfg.fast_off_ms  <= RST_FAST_OFF;
            r_cfg.slow_on_ms   <= RST_SLOW_ON;
            r_cfg.slow_off_ms  <= RST_SLOW_OFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP:      r_cfg.step_ms      <= i_cfg_data[STEP_W-1:0];
                CFG_STEADY_ON: r_cfg.steady_on_ms <= i_cfg_data;
                CFG_FAST_ON:   r_cfg.fast_on_ms   <= i_cfg_data;
                CFG_FAST_OFF:  r_cfg.fast_off_ms  <= i_cfg_data;
                CFG_SLOW_ON:   r_cfg.slow_on_ms   <= i_cfg_data;
                CFG_SLOW_OFF:  r_cfg.slow_off_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/lbpc_seq.sv @@
// ----------------------------------------------------------------------------
// lbpc_seq
// Blink sequencer state and its one-item update: tick steps and set commands.
// ----------------------------------------------------------------------------
module lbpc_seq
    import lbpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    t_phase             r_phase,   n_phase;
    t_time              r_elapsed, n_elapsed;
    t_time              r_on,      n_on;
    t_time              r_off,     n_off;
    logic [COUNT_W-1:0] r_cycles,  n_cycles;
    logic               r_running, n_running;
    logic [1:0]         r_mode,    n_mode;
    logic               r_pin,     n_pin;

    logic [CMP_W-1:0]   w_sum;
    t_time              w_tick_elapsed;
    logic [COUNT_W-1:0] w_dec;
    logic [REG_W-1:0]   w_on_sel;
    logic [REG_W-1:0]   w_off_sel;

    // saturating time advance for a tick
    assign w_sum = CMP_W'(r_elapsed) + CMP_W'(i_cfg.step_ms);
    assign w_tick_elapsed = (w_sum > CMP_W'(TIME_MAX)) ? TIME_MAX : TIME_W'(w_sum);
    assign w_dec = r_cycles - COUNT_W'(1);

    always_comb begin
        w_on_sel  = '0;
        w_off_sel = '0;
        unique case (i_item.mode_sel)
            MODE_OFF: ;
            MODE_ON: begin
                w_on_sel = i_cfg.steady_on_ms;
            end
            MODE_FAST: begin
                w_on_sel  = i_cfg.fast_on_ms;
                w_off_sel = i_cfg.fast_off_ms;
            end
            MODE_SLOW: begin
                w_on_sel  = i_cfg.slow_on_ms;
                w_off_sel = i_cfg.slow_off_ms;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_on      = r_on;
        n_off     = r_off;
        n_cycles  = r_cycles;
        n_running = r_running;
        n_mode    = r_mode;
        n_pin     = r_pin;
        if (i_item.func == FUNC_TICK) begin
            n_elapsed = w_tick_elapsed;
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_cycles != '0) begin
                        n_running = 1'b1;
                        n_phase   = (r_on == '0 && r_off == '0) ? PH_END : PH_TURN_ON;
                    end else if (r_running) begin
                        n_phase = PH_END;
                    end
                end
                PH_TURN_ON: begin
                    if (r_on != '0) begin
                        n_pin     = PIN_LIT;
                        n_elapsed = '0;
                        n_phase   = PH_ON_WAIT;
                    end else begin
                        n_phase = PH_TURN_OFF;
                    end
                end
                PH_ON_WAIT: begin
                    if (w_tick_elapsed >= r_on) begin
                        n_phase = PH_TURN_OFF;
                    end
                end
                PH_TURN_OFF: begin
                    if (r_off != '0) begin
                        n_pin     = PIN_DARK;
                        n_elapsed = '0;
                        n_phase   = PH_OFF_WAIT;
                    end else begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_OFF_WAIT: begin
                    if (w_tick_elapsed >= r_off) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    // negative count blinks forever
                    if (r_cycles[COUNT_W-1]) begin
                        n_phase = PH_TURN_ON;
                    end else if (r_cycles != '0) begin
                        n_cycles = w_dec;
                        n_phase  = (w_dec == '0) ? PH_END : PH_TURN_ON;
                    end else begin
                        n_phase = PH_END;
                    end
                end
                PH_KICK: begin
                    n_pin   = PIN_DARK;
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_pin     = PIN_DARK;
                    n_cycles  = '0;
                    n_phase   = PH_IDLE;
                    n_running = 1'b0;
                end
            endcase
        end else if (i_item.mode_sel != r_mode) begin
            n_mode    = i_item.mode_sel;
            n_on      = sat_period(w_on_sel);
            n_off     = sat_period(w_off_sel);
            n_cycles  = i_item.repeat_count;
            n_phase   = PH_KICK;
            n_running = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_on      <= '0;
            r_off     <= '0;
            r_cycles  <= '0;
            r_running <= 1'b0;
            r_mode    <= MODE_OFF;
            r_pin     <= PIN_DARK;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_on      <= n_on;
            r_off     <= n_off;
            r_cycles  <= n_cycles;
            r_running <= n_running;
            r_mode    <= n_mode;
            r_pin     <= n_pin;
        end
    end

    assign o_res.led_level  = n_pin;
    assign o_res.is_running = n_running;

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("sequencer phase not one-hot");

    a_stopped_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_phase == PH_IDLE))
        else $error("sequencer left idle while not running");

    a_lit_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pin == PIN_LIT) |-> r_running)
        else $error("led lit with no active sequence");

    a_on_wait_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ON_WAIT) |-> (r_pin == PIN_LIT))
        else $error("on wait with led dark");

    a_off_wait_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OFF_WAIT) |-> (r_pin == PIN_DARK))
        else $error("off wait with led lit");

endmodule

@@ src/led_blink_pattern_controller.sv @@
// ----------------------------------------------------------------------------
// led_blink_pattern_controller
// Active-low led blink sequencer driven by tick and set-mode items.
//
//  channel   dir  handshake                tdata / tuser
//  s_axis    in   tvalid/tready            tdata: mode_sel, repeat_count
//                                          tuser: func
//  m_axis    out  tvalid/tready            tdata: led_level, is_running
//  cfg       in   i_cfg_valid/o_cfg_ready  index + 16-bit data
//
// one item per cycle sustained unless the result stalls; an accepted item is
// held in the input register, then registered in the result register.
// each item gives exactly one result item.
// a stalled result holds the result register and the input register fills;
// input ready drops only when both are occupied.
// reset is synchronous; config writes are always taken (o_cfg_ready is tied high).
// ----------------------------------------------------------------------------
module led_blink_pattern_controller
    import lbpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [23:0]        i_s_axis_tdata,  // [1:0] mode_sel, [17:2] repeat_count
    input  logic [0:0]         i_s_axis_tuser,  // [0] func
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,  // [0] led_level, [1] is_running
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [INDEX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]   i_cfg_data
);

    t_cfg  w_cfg;
    t_res  w_res;
    t_item r_in;
    logic  r_in_valid;
    t_res  r_out;
    logic  r_out_valid;
    logic  w_proc;
    logic  w_in_acc;

    assign o_cfg_ready = 1'b1;

    lbpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // item moves from input register to result register
    assign w_proc          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_proc;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.func         <= i_s_axis_tuser[0];
            r_in.mode_sel     <= i_s_axis_tdata[1:0];
            r_in.repeat_count <= i_s_axis_tdata[17:2];
        end
    end

    lbpc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_proc),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out.is_running, r_out.led_level};

endmodule
